### hdl/dtp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the date/time text parser.
// No dependencies; imported by date_time_text_parser_core and its testbench.
package dtp_pkg;

  // Parse position within "[ ]M[M]/D[D]/YY[ ]H[H]:M[M]:SS[ ]am|pm"
  typedef enum logic [4:0] {
    PH_START  = 5'd0,
    PH_MON1   = 5'd1,
    PH_MON2   = 5'd2,
    PH_MONSEP = 5'd3,
    PH_DAT1   = 5'd4,
    PH_DAT2   = 5'd5,
    PH_DATSEP = 5'd6,
    PH_YR1    = 5'd7,
    PH_YR2    = 5'd8,
    PH_HRSP   = 5'd9,
    PH_HR1    = 5'd10,
    PH_HR2    = 5'd11,
    PH_HRSEP  = 5'd12,
    PH_MIN1   = 5'd13,
    PH_MIN2   = 5'd14,
    PH_MINSEP = 5'd15,
    PH_SEC1   = 5'd16,
    PH_SEC2   = 5'd17,
    PH_APSP   = 5'd18,
    PH_AP     = 5'd19,
    PH_M      = 5'd20
  } phase_t;

  localparam logic [7:0] CH_0     = 8'd48;
  localparam logic [7:0] CH_9     = 8'd57;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_M     = 8'h6D;

  localparam logic [6:0] MAX_MONTH = 7'd12;
  localparam logic [6:0] MAX_DATE  = 7'd31;
  localparam logic [6:0] MAX_YEAR  = 7'd99;
  localparam logic [6:0] MAX_HOURS = 7'd12;
  localparam logic [6:0] MAX_MS    = 7'd59;

  localparam int OUT_DATA_W = 40;

endpackage

### hdl/date_time_text_parser_core.sv
`timescale 1ns / 1ps
// Date/time text parser: one ASCII character per transfer, one verdict per string.
// Depends on dtp_pkg (phase type, character codes, range limits).
//
// Channel  | Dir | tdata                          | tuser | tlast
// ---------+-----+--------------------------------+-------+------
// in_      | in  | [7:0] character                | first | last
// out_     | out | held time (see port comment)   | ok    | -
//
// Cycles: one character per clock unless stalled; parsed in the cycle it is
// accepted; its verdict (if any) sits in the output register the next cycle.
// Throughput is set by the single output register: in_tready is high when the
// register is empty or being drained, so with out_tready high the block takes
// a character every cycle.
// Reset (rst_n low, synchronous): parser idle waiting for a first-marked
// character, held time cleared to zero, output register empty.
// Stalls: a held verdict stalls input only while out_tready is low.
module date_time_text_parser_core
  import dtp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input character stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] character
  input  logic        in_tuser,   // first: restarts the parser
  input  logic        in_tlast,   // last: undecided string fails here
  // verdict stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata, // [3:0] month, [8:4] date, [15:9] year,
                                           // [19:16] hours, [25:20] minutes,
                                           // [31:26] seconds, [32] pm, [39:33] zero
  output logic        out_tuser   // ok: string accepted, held time updated
);

  // ---------------------------------------------------------------- state
  phase_t     phase_r, phase_nxt;
  logic       decided_r, decided_nxt;
  logic [6:0] acc_r, acc_nxt;
  logic [6:0] pend_month_r, pend_month_nxt;
  logic [6:0] pend_date_r, pend_date_nxt;
  logic [6:0] pend_year_r, pend_year_nxt;
  logic [6:0] pend_hours_r, pend_hours_nxt;
  logic [6:0] pend_min_r, pend_min_nxt;
  logic       pend_pm_r, pend_pm_nxt;

  // held time, last accepted string
  logic [3:0] held_month_r, held_month_nxt;
  logic [4:0] held_date_r, held_date_nxt;
  logic [6:0] held_year_r, held_year_nxt;
  logic [3:0] held_hours_r, held_hours_nxt;
  logic [5:0] held_min_r, held_min_nxt;
  logic [5:0] held_sec_r, held_sec_nxt;
  logic       held_pm_r, held_pm_nxt;

  // output register
  logic                  out_valid_r;
  logic                  out_ok_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  // ---------------------------------------------------------------- parse step
  logic       in_fire;
  logic       live;       // string open: restarted now or not yet decided
  phase_t     ph;         // effective phase for this character
  logic [7:0] c;
  logic       is_dig;
  logic [3:0] dval;
  logic [9:0] acc_sum;
  logic [6:0] two_dig;
  logic [7:0] sep;
  logic       store_sep;  // separator closes a field
  logic       rej;
  logic       accept;
  logic       emit;
  logic       in_range;

  assign in_fire   = in_tvalid && in_tready;
  assign in_tready = !out_valid_r || out_tready;

  always_comb begin
    c       = in_tdata;
    ph      = in_tuser ? PH_START : phase_r;
    live    = in_tuser || !decided_r;
    is_dig  = (c >= CH_0) && (c <= CH_9);
    dval    = is_dig ? c[3:0] : 4'd0;
    // acc*10 + digit, kept to 7 bits
    acc_sum = {acc_r, 3'b000} + {2'b00, acc_r, 1'b0} + {6'd0, dval};
    two_dig = acc_sum[6:0];
    sep     = (ph == PH_MON2 || ph == PH_DAT2 || ph == PH_MONSEP || ph == PH_DATSEP) ?
              CH_SLASH : CH_COLON;
    in_range = (pend_month_r <= MAX_MONTH) && (pend_date_r <= MAX_DATE) &&
               (pend_year_r <= MAX_YEAR) && (pend_hours_r <= MAX_HOURS) &&
               (pend_min_r <= MAX_MS) && (acc_r <= MAX_MS);

    phase_nxt      = phase_r;
    acc_nxt        = acc_r;
    pend_month_nxt = pend_month_r;
    pend_date_nxt  = pend_date_r;
    pend_year_nxt  = pend_year_r;
    pend_hours_nxt = pend_hours_r;
    pend_min_nxt   = pend_min_r;
    pend_pm_nxt    = pend_pm_r;
    store_sep      = 1'b0;
    rej            = 1'b0;
    accept         = 1'b0;

    case (ph)
      PH_START: begin
        if (c == CH_SPACE) begin
          phase_nxt = PH_MON1;
        end else if (is_dig) begin
          acc_nxt   = {3'd0, dval};
          phase_nxt = PH_MON2;
        end else begin
          rej = 1'b1;
        end
      end
      PH_MON1, PH_DAT1, PH_YR1, PH_HR1, PH_MIN1, PH_SEC1: begin
        if (is_dig) begin
          acc_nxt   = {3'd0, dval};
          phase_nxt = phase_t'(ph + 5'd1);
        end else begin
          rej = 1'b1;
        end
      end
      PH_MON2, PH_DAT2, PH_HR2, PH_MIN2: begin
        if (is_dig) begin
          acc_nxt   = two_dig;
          phase_nxt = phase_t'(ph + 5'd1);
        end else if (c == sep) begin
          // single-digit field: separator closes it right away
          store_sep = 1'b1;
          phase_nxt = phase_t'(ph + 5'd2);
        end else begin
          rej = 1'b1;
        end
      end
      PH_MONSEP, PH_DATSEP, PH_HRSEP, PH_MINSEP: begin
        if (c == sep) begin
          store_sep = 1'b1;
          phase_nxt = phase_t'(ph + 5'd1);
        end else begin
          rej = 1'b1;
        end
      end
      PH_YR2: begin
        if (is_dig) begin
          pend_year_nxt = two_dig;
          phase_nxt     = PH_HRSP;
        end else begin
          rej = 1'b1;
        end
      end
      PH_HRSP: begin
        if (c == CH_SPACE) begin
          phase_nxt = PH_HR1;
        end else if (is_dig) begin
          acc_nxt   = {3'd0, dval};
          phase_nxt = PH_HR2;
        end else begin
          rej = 1'b1;
        end
      end
      PH_SEC2: begin
        if (is_dig) begin
          acc_nxt   = two_dig;
          phase_nxt = PH_APSP;
        end else begin
          rej = 1'b1;
        end
      end
      PH_APSP, PH_AP: begin
        if (ph == PH_APSP && c == CH_SPACE) begin
          phase_nxt = PH_AP;
        end else if (c == CH_A) begin
          pend_pm_nxt = 1'b0;
          phase_nxt   = PH_M;
        end else if (c == CH_P) begin
          pend_pm_nxt = 1'b1;
          phase_nxt   = PH_M;
        end else begin
          rej = 1'b1;
        end
      end
      PH_M: begin
        if (c == CH_M && in_range) begin
          accept = 1'b1;
        end else begin
          rej = 1'b1;
        end
      end
      default: begin
        rej = 1'b1;
      end
    endcase

    if (store_sep) begin
      case (ph)
        PH_MON2, PH_MONSEP: pend_month_nxt = acc_r;
        PH_DAT2, PH_DATSEP: pend_date_nxt  = acc_r;
        PH_HR2, PH_HRSEP:   pend_hours_nxt = acc_r;
        default:            pend_min_nxt   = acc_r;
      endcase
    end

    emit        = live && (rej || accept || in_tlast);
    decided_nxt = live ? (rej || accept || in_tlast) : decided_r;

    held_month_nxt = accept ? pend_month_r[3:0] : held_month_r;
    held_date_nxt  = accept ? pend_date_r[4:0]  : held_date_r;
    held_year_nxt  = accept ? pend_year_r       : held_year_r;
    held_hours_nxt = accept ? pend_hours_r[3:0] : held_hours_r;
    held_min_nxt   = accept ? pend_min_r[5:0]   : held_min_r;
    held_sec_nxt   = accept ? acc_r[5:0]        : held_sec_r;
    held_pm_nxt    = accept ? pend_pm_r         : held_pm_r;
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_START;
      decided_r    <= 1'b1;
      acc_r        <= 7'd0;
      pend_month_r <= 7'd0;
      pend_date_r  <= 7'd0;
      pend_year_r  <= 7'd0;
      pend_hours_r <= 7'd0;
      pend_min_r   <= 7'd0;
      pend_pm_r    <= 1'b0;
      held_month_r <= 4'd0;
      held_date_r  <= 5'd0;
      held_year_r  <= 7'd0;
      held_hours_r <= 4'd0;
      held_min_r   <= 6'd0;
      held_sec_r   <= 6'd0;
      held_pm_r    <= 1'b0;
    end else if (in_fire && live) begin
      phase_r      <= phase_nxt;
      decided_r    <= decided_nxt;
      acc_r        <= acc_nxt;
      pend_month_r <= pend_month_nxt;
      pend_date_r  <= pend_date_nxt;
      pend_year_r  <= pend_year_nxt;
      pend_hours_r <= pend_hours_nxt;
      pend_min_r   <= pend_min_nxt;
      pend_pm_r    <= pend_pm_nxt;
      held_month_r <= held_month_nxt;
      held_date_r  <= held_date_nxt;
      held_year_r  <= held_year_nxt;
      held_hours_r <= held_hours_nxt;
      held_min_r   <= held_min_nxt;
      held_sec_r   <= held_sec_nxt;
      held_pm_r    <= held_pm_nxt;
    end
  end

  // output register: loads a verdict, clears when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      out_ok_r   <= accept;
      out_data_r <= {7'd0, held_pm_nxt, held_sec_nxt, held_min_nxt, held_hours_nxt,
                     held_year_nxt, held_date_nxt, held_month_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_ok_r;
  assign out_tdata  = out_data_r;

  // ---------------------------------------------------------------- assertions
  // accepted verdicts always carry an in-range time
  a_ok_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |->
      (out_tdata[3:0] <= 4'd12) && (out_tdata[8:4] <= 5'd31) &&
      (out_tdata[19:16] <= 4'd12) && (out_tdata[25:20] <= 6'd59) &&
      (out_tdata[31:26] <= 6'd59))
    else $error("accepted time out of range");

  // a last character of an open string always yields a verdict
  a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tlast && (in_tuser || !decided_r)) |=> out_tvalid)
    else $error("open string ended without verdict");

  // held time moves only on an accepted string
  a_held_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_fire && live && accept) |=>
      ($stable(held_month_r) && $stable(held_date_r) && $stable(held_year_r) &&
       $stable(held_hours_r) && $stable(held_min_r) && $stable(held_sec_r) &&
       $stable(held_pm_r)))
    else $error("held time changed without acceptance");

endmodule

### dv/tb_date_time_text_parser_core.sv
`timescale 1ns / 1ps
// Self-checking bench for date_time_text_parser_core: streams timestamp strings,
// predicts each verdict and the held time, and checks them in order.
// Depends on dtp_pkg and date_time_text_parser_core.
module tb_date_time_text_parser_core;
  import dtp_pkg::*;

  localparam int ITEMS_PER_MODE = 640;
  localparam int CYCLE_LIMIT    = 200000;

  typedef struct packed {
    logic [7:0] ch;
    logic       is_first;
    logic       is_last;
  } char_xfer_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] month;
    logic [4:0] date;
    logic [6:0] year;
    logic [3:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic       pm;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = 8'd0;  // [7:0] character
  logic in_tuser = 1'b0;        // first
  logic in_tlast = 1'b0;        // last
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;  // month, date, year, hours, minutes, seconds, pm, pad
  logic out_tuser;                   // ok

  char_xfer_t char_q[$];
  verdict_t   verdict_q[$];
  logic [7:0] str_buf[$];
  char_xfer_t drv_item;

  int tx_idle_pct = 6;
  int rx_idle_pct = 79;
  int err_cnt = 0;
  int cycle_cnt = 0;
  int hold_left = 0;
  int verdicts_seen = 0;

  // parser state mirror
  phase_t     parse_phase = PH_START;
  logic [6:0] digits_acc = '0;
  logic [6:0] pend_month = '0, pend_date = '0, pend_year = '0;
  logic [6:0] pend_hours = '0, pend_minutes = '0;
  logic       pend_pm = 1'b0;
  logic       decided = 1'b1;
  logic [3:0] held_month = '0;
  logic [4:0] held_date = '0;
  logic [6:0] held_year = '0;
  logic [3:0] held_hours = '0;
  logic [5:0] held_minutes = '0;
  logic [5:0] held_seconds = '0;
  logic       held_pm = 1'b0;

  date_time_text_parser_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #2 clk = ~clk;

  function automatic logic [6:0] shift_in_digit(input logic [6:0] acc, input logic [6:0] d);
    int t;
    t = acc * 10 + d;
    return t[6:0];
  endfunction

  // -1 still undecided, 0 rejected, 1 accepted
  function automatic int consume_char(input logic [7:0] c);
    phase_t     ph;
    logic       dig;
    logic [6:0] d;
    logic [7:0] sep;
    ph  = parse_phase;
    dig = (c >= CH_0) && (c <= CH_9);
    d   = dig ? 7'(c - CH_0) : 7'd0;
    if (ph == PH_START) begin
      if (c == CH_SPACE) begin
        parse_phase = PH_MON1;
        return -1;
      end
      ph = PH_MON1;  // no leading space: this is the first month digit
    end
    case (ph)
      PH_MON1, PH_DAT1, PH_YR1, PH_HR1, PH_MIN1, PH_SEC1: begin
        if (!dig) return 0;
        digits_acc  = d;
        parse_phase = phase_t'(ph + 1);
        return -1;
      end
      PH_MON2, PH_DAT2, PH_HR2, PH_MIN2: begin
        if (dig) begin
          digits_acc  = shift_in_digit(digits_acc, d);
          parse_phase = phase_t'(ph + 1);
          return -1;
        end
        ph = phase_t'(ph + 1);  // single digit: this char must be the separator
      end
      PH_YR2: begin
        if (!dig) return 0;
        pend_year   = shift_in_digit(digits_acc, d);
        parse_phase = PH_HRSP;
        return -1;
      end
      PH_HRSP: begin
        if (c == CH_SPACE) begin
          parse_phase = PH_HR1;
          return -1;
        end
        if (!dig) return 0;
        digits_acc  = d;
        parse_phase = PH_HR2;
        return -1;
      end
      PH_SEC2: begin
        if (!dig) return 0;
        digits_acc  = shift_in_digit(digits_acc, d);
        parse_phase = PH_APSP;
        return -1;
      end
      PH_APSP: begin
        if (c == CH_SPACE) begin
          parse_phase = PH_AP;
          return -1;
        end
        ph = PH_AP;
      end
      PH_M: begin
        if (c != CH_M) return 0;
        if (pend_month > MAX_MONTH || pend_date > MAX_DATE || pend_year > MAX_YEAR ||
            pend_hours > MAX_HOURS || pend_minutes > MAX_MS || digits_acc > MAX_MS)
          return 0;
        held_month   = pend_month[3:0];
        held_date    = pend_date[4:0];
        held_year    = pend_year;
        held_hours   = pend_hours[3:0];
        held_minutes = pend_minutes[5:0];
        held_seconds = digits_acc[5:0];
        held_pm      = pend_pm;
        return 1;
      end
      default: ;
    endcase
    if (ph == PH_MONSEP || ph == PH_DATSEP || ph == PH_HRSEP || ph == PH_MINSEP) begin
      sep = (ph == PH_MONSEP || ph == PH_DATSEP) ? CH_SLASH : CH_COLON;
      if (c != sep) return 0;
      if (ph == PH_MONSEP) pend_month = digits_acc;
      else if (ph == PH_DATSEP) pend_date = digits_acc;
      else if (ph == PH_HRSEP) pend_hours = digits_acc;
      else pend_minutes = digits_acc;
      parse_phase = phase_t'(ph + 1);
      return -1;
    end
    if (ph == PH_AP) begin
      if (c == CH_A) pend_pm = 1'b0;
      else if (c == CH_P) pend_pm = 1'b1;
      else return 0;
      parse_phase = PH_M;
      return -1;
    end
    return 0;
  endfunction

  task automatic predict_verdict(input logic [7:0] c, input logic is_first,
                                 input logic is_last);
    int       res;
    verdict_t v;
    if (is_first) begin
      parse_phase  = PH_START;
      digits_acc   = '0;
      pend_month   = '0;
      pend_date    = '0;
      pend_year    = '0;
      pend_hours   = '0;
      pend_minutes = '0;
      pend_pm      = 1'b0;
      decided      = 1'b0;
    end
    if (decided) return;
    res = consume_char(c);
    if (res < 0 && is_last) res = 0;
    if (res < 0) return;
    decided   = 1'b1;
    v.ok      = (res == 1);
    v.month   = held_month;
    v.date    = held_date;
    v.year    = held_year;
    v.hours   = held_hours;
    v.minutes = held_minutes;
    v.seconds = held_seconds;
    v.pm      = held_pm;
    verdict_q.push_back(v);
  endtask

  task automatic cmp_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_val, act_val);
      err_cnt++;
    end
  endtask

  task automatic check_verdict(input logic ok, input logic [OUT_DATA_W-1:0] d);
    verdict_t v;
    if (verdict_q.size() == 0) begin
      $display("%0t: unexpected verdict, expected none actual ok=%0b data=%h",
               $time, ok, d);
      err_cnt++;
      return;
    end
    v = verdict_q.pop_front();
    cmp_field("ok", v.ok, ok);
    cmp_field("month", v.month, d[3:0]);
    cmp_field("date", v.date, d[8:4]);
    cmp_field("year", v.year, d[15:9]);
    cmp_field("hours", v.hours, d[19:16]);
    cmp_field("minutes", v.minutes, d[25:20]);
    cmp_field("seconds", v.seconds, d[31:26]);
    cmp_field("pm", v.pm, d[32]);
    cmp_field("pad", 0, d[39:33]);
  endtask

  // ---- stimulus helpers ----
  task automatic push_char(input logic [7:0] c, input logic is_first, input logic is_last);
    char_xfer_t x;
    x.ch       = c;
    x.is_first = is_first;
    x.is_last  = is_last;
    char_q.push_back(x);
  endtask

  function automatic int pick_value(input int hi);
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return hi;
      2:       return hi + 1;  // just past the limit
      3:       return $urandom_range(0, 99);
      default: return $urandom_range(0, hi);
    endcase
  endfunction

  // mostly characters that the grammar cares about, sometimes any byte
  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 7))
      0:       return CH_SPACE;
      1:       return CH_SLASH;
      2:       return CH_COLON;
      3:       return CH_A;
      4:       return CH_P;
      5:       return CH_M;
      6:       return 8'(CH_0 + $urandom_range(0, 9));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic append_field(input int val, input bit two_digits);
    if (!two_digits && val < 10 && $urandom_range(0, 1) == 1) begin
      str_buf.push_back(8'(CH_0 + val));
    end else begin
      str_buf.push_back(8'(CH_0 + val / 10));
      str_buf.push_back(8'(CH_0 + val % 10));
    end
  endtask

  // One timestamp string, sometimes damaged. n = characters that count as parser work.
  task automatic queue_timestamp(output int n);
    int  k;
    bit  no_first;
    bit  mark_last;
    str_buf.delete();
    no_first  = 0;
    mark_last = ($urandom_range(0, 99) < 85);
    if ($urandom_range(0, 1) == 1) str_buf.push_back(CH_SPACE);
    append_field(pick_value(12), 0);
    str_buf.push_back(CH_SLASH);
    append_field(pick_value(31), 0);
    str_buf.push_back(CH_SLASH);
    append_field($urandom_range(0, 99), 1);
    if ($urandom_range(0, 1) == 1) str_buf.push_back(CH_SPACE);
    append_field(pick_value(12), 0);
    str_buf.push_back(CH_COLON);
    append_field(pick_value(59), 0);
    str_buf.push_back(CH_COLON);
    append_field(pick_value(59), 1);
    if ($urandom_range(0, 1) == 1) str_buf.push_back(CH_SPACE);
    str_buf.push_back(($urandom_range(0, 1) == 1) ? CH_A : CH_P);
    str_buf.push_back(CH_M);
    case ($urandom_range(0, 11))
      0: str_buf[$urandom_range(0, str_buf.size() - 1)] = pick_char();
      1: repeat ($urandom_range(1, str_buf.size() - 1)) void'(str_buf.pop_back());
      2: str_buf.insert($urandom_range(0, str_buf.size() - 1), pick_char());
      3: no_first = 1;
      default: ;
    endcase
    for (int i = 0; i < str_buf.size(); i++)
      push_char(str_buf[i], (i == 0) && !no_first, (i == str_buf.size() - 1) && mark_last);
    n = str_buf.size();
    // trailing characters with no first mark, ignored once the string is decided
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) push_char(pick_char(), 1'b0, 1'b0);
  endtask

  task automatic queue_noise(output int n);
    n = $urandom_range(1, 4);
    repeat (n)
      push_char(8'($urandom_range(0, 255)), $urandom_range(0, 2) == 0,
                $urandom_range(0, 2) == 0);
  endtask

  // ---- driver: one item offered per transfer, gaps at tx_idle_pct ----
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) predict_verdict(in_tdata, in_tuser, in_tlast);
      if (!in_tvalid || in_tready) begin
        if (char_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          drv_item = char_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= drv_item.ch;
          in_tuser  <= drv_item.is_first;
          in_tlast  <= drv_item.is_last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---- monitor: checks verdicts, stalls at rx_idle_pct plus long hold-offs ----
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        check_verdict(out_tuser, out_tdata);
        verdicts_seen++;
        // long back-pressure so the output register fills and input stalls
        if (verdicts_seen == 20 || verdicts_seen == 70) hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (rx_idle_pct != 0 && $urandom_range(0, 1999) == 0) begin
        hold_left = $urandom_range(40, 160);
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int    n;
    int    queued;
    string fixed_str;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (int mode = 0; mode < 3; mode++) begin
      tx_idle_pct = (mode == 0) ? 6 : (mode == 1) ? 79 : 0;
      rx_idle_pct = (mode == 0) ? 79 : (mode == 1) ? 6 : 0;
      if (mode == 0) begin
        // before any first mark: ignored
        push_char("Z", 1'b0, 1'b0);
        // month/date 1, other fields zero, no leading space, verdict on last character
        str_buf.delete();
        fixed_str = "1/1/00 0:0:00am";
        foreach (fixed_str[i]) str_buf.push_back(fixed_str[i]);
        for (int i = 0; i < str_buf.size(); i++)
          push_char(str_buf[i], i == 0, i == str_buf.size() - 1);
        // bad character rejects at once, the next one is ignored
        push_char("q", 1'b1, 1'b0);
        push_char("5", 1'b0, 1'b0);
        // first and last together on an undecided string
        push_char("7", 1'b1, 1'b1);
      end
      queued = 0;
      while (queued < ITEMS_PER_MODE) begin
        if ($urandom_range(0, 9) == 0) queue_noise(n);
        else queue_timestamp(n);
        queued += n;
      end
      // sampled mid-cycle so the driver's updates at the edge have settled
      while (char_q.size() != 0 || in_tvalid) @(negedge clk);
    end

    while (verdict_q.size() != 0) @(negedge clk);
    repeat (10) @(posedge clk);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### sim.f
hdl/dtp_pkg.sv
hdl/date_time_text_parser_core.sv
dv/tb_date_time_text_parser_core.sv
